### hdl/gof_pkg.sv
// shared types, constants and the outline arithmetic for the glyph outline filter
package gof_pkg;

   localparam int ALPHA_W     = 8;
   localparam int POS_W       = 10;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 1;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int RESET_SIZE     = 1024;

   localparam int ROW_BUFS    = 3;
   localparam int MAX_RESULTS = 2;

   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);
   localparam int RSP_SUM_W   = RSP_CNT_W + 2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   localparam logic [ALPHA_W-1:0] BODY_BASE = 8'd128;

   typedef struct packed {
      logic [ALPHA_W-1:0] up;
      logic [ALPHA_W-1:0] mid;
      logic [ALPHA_W-1:0] dn;
   } gof_col_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic               last;
   } gof_rsp_type;

   function automatic logic [ALPHA_W-1:0] max4(
      input logic [ALPHA_W-1:0] a,
      input logic [ALPHA_W-1:0] b,
      input logic [ALPHA_W-1:0] c,
      input logic [ALPHA_W-1:0] d
   );
      logic [ALPHA_W-1:0] m_ab;
      logic [ALPHA_W-1:0] m_cd;
      m_ab = (a > b) ? a : b;
      m_cd = (c > d) ? c : d;
      return (m_ab > m_cd) ? m_ab : m_cd;
   endfunction

   // 3x3 outline of the center column c, left l, right r
   function automatic logic [ALPHA_W-1:0] outline(
      input gof_col_type l,
      input gof_col_type c,
      input gof_col_type r,
      input logic        border
   );
      logic [ALPHA_W-1:0]   n1;
      logic [ALPHA_W-1:0]   n2;
      logic [ALPHA_W+1:0]   sum;
      logic [ALPHA_W-1:0]   glow;
      logic [ALPHA_W-1:0]   v;
      n1   = max4(l.mid, r.mid, c.up, c.dn);
      n2   = max4(l.up, r.up, l.dn, r.dn);
      // 3*n1 + n2 as 2*n1 + n1 + n2
      sum  = {1'b0, n1, 1'b0} + {2'b00, n1} + {2'b00, n2};
      glow = sum[ALPHA_W+1:2];
      if (c.mid == '0) begin
         v = {1'b0, glow[ALPHA_W-1:1]};
      end else begin
         v = {1'b0, c.mid[ALPHA_W-1:1]} + BODY_BASE;
      end
      if (border && (v > BODY_BASE)) begin
         v = {1'b0, v[ALPHA_W-1:1]};
      end
      return v;
   endfunction

endpackage

### hdl/gof_row_ram.sv
// one row store: single write port, two registered read ports with write-through
module gof_row_ram #(
   parameter  int DEPTH = gof_pkg::DEF_MAX_WIDTH,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [gof_pkg::ALPHA_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr_a,
   input  logic [AW-1:0]               rd_addr_b,
   output logic [gof_pkg::ALPHA_W-1:0] rd_data_a,
   output logic [gof_pkg::ALPHA_W-1:0] rd_data_b
);

   logic [gof_pkg::ALPHA_W-1:0] mem [DEPTH];
   logic [gof_pkg::ALPHA_W-1:0] rd_a_ff;
   logic [gof_pkg::ALPHA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
      rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### hdl/gof_rsp_fifo.sv
// result queue: up to two words pushed per cycle, one popped
module gof_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_a,
   input  gof_pkg::gof_rsp_type          push_data_a,
   input  logic                          push_b,
   input  gof_pkg::gof_rsp_type          push_data_b,
   input  logic                          pop,
   output logic                          out_valid,
   output gof_pkg::gof_rsp_type          out_data,
   output logic [gof_pkg::RSP_CNT_W-1:0] fill
);

   gof_pkg::gof_rsp_type entry_ff [gof_pkg::RSP_DEPTH];

   logic [gof_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [gof_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [gof_pkg::RSP_CNT_W-1:0] fill_ff, fill_in;
   logic [gof_pkg::RSP_PTR_W-1:0] b_ptr;
   logic [gof_pkg::RSP_CNT_W-1:0] n_push;

   // lane b lands behind lane a when both push
   assign b_ptr  = push_a ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign n_push = gof_pkg::RSP_CNT_W'(push_a) + gof_pkg::RSP_CNT_W'(push_b);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + gof_pkg::RSP_PTR_W'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + n_push - gof_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         entry_ff[wr_ptr_ff] <= push_data_a;
      end
      if (push_b) begin
         entry_ff[b_ptr] <= push_data_b;
      end
   end

   assign out_valid = (fill_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign fill      = fill_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (gof_pkg::RSP_SUM_W'(fill_ff) + gof_pkg::RSP_SUM_W'(n_push)) <=
      (gof_pkg::RSP_SUM_W'(gof_pkg::RSP_DEPTH) + gof_pkg::RSP_SUM_W'(pop)))
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (fill_ff != '0))
      else $error("result queue popped while empty");

   a_ptr_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= gof_pkg::RSP_CNT_W'(gof_pkg::RSP_DEPTH)) &&
      ((wr_ptr_ff - rd_ptr_ff) == gof_pkg::RSP_PTR_W'(fill_ff)))
      else $error("result queue pointers disagree with fill");

endmodule

### hdl/glyph_outline_filter_core.sv
// glyph outline filter top: 3x3 max dilation with glow falloff over a raster alpha stream
// an accepted item is registered in the input stage; its words then enter the result queue
// throughput: one item per cycle while results drain; an item that yields two words (row end)
//   can hold ready low, since ready needs room for two words in the four-entry result queue
// reset: counters, frame state and the result queue clear; size registers return to 1024;
//   the three row stores are not cleared and need no clearing pass
module glyph_outline_filter_core #(
   parameter int MAX_WIDTH  = gof_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gof_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   // item channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [gof_pkg::ALPHA_W-1:0]    req_alpha_in,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [gof_pkg::ALPHA_W-1:0]    rsp_alpha_out,
   output logic [gof_pkg::POS_W-1:0]      rsp_out_row,
   output logic [gof_pkg::POS_W-1:0]      rsp_out_col,
   output logic                           rsp_frame_last,
   // size registers
   input  logic                           csr_wr_en,
   input  logic [gof_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gof_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int RST_W = (gof_pkg::RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : gof_pkg::RESET_SIZE;
   localparam int RST_H = (gof_pkg::RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : gof_pkg::RESET_SIZE;

   // ---------------------------------------------------------------------------------------
   // frame position and size state
   // sizes are kept as the clamped index of the last column / row
   // ---------------------------------------------------------------------------------------
   logic [CW-1:0] wlast_ff, wlast_in;
   logic [RW-1:0] hlast_ff, hlast_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] flush_ff, flush_in;
   logic          done_ff, done_in;     // all samples in, waiting for flush ticks
   logic [1:0]    ph_ff, ph_in;         // which physical store receives the current row
   logic [1:0]    next_ph;

   logic [CW-1:0] csr_w_last;
   logic [RW-1:0] csr_h_last;

   logic          req_acc;
   logic          smp_acc;
   logic          fl_acc;
   logic          item_acc;
   logic          col_last;

   assign req_acc  = req_valid && req_ready;
   // samples after the frame is complete and flush ticks before it are dropped
   assign smp_acc  = req_acc && (req_kind == gof_pkg::KIND_SAMPLE) && !done_ff;
   assign fl_acc   = req_acc && (req_kind == gof_pkg::KIND_FLUSH) && done_ff;
   assign item_acc = smp_acc || fl_acc;
   assign col_last = (col_ff == wlast_ff);
   assign next_ph  = (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;

   // zero acts as one, anything beyond the build maximum acts as the maximum
   assign csr_w_last = (csr_wr_data == '0) ? '0 :
                       (32'(csr_wr_data) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) :
                       CW'(csr_wr_data - 1'b1);
   assign csr_h_last = (csr_wr_data == '0) ? '0 :
                       (32'(csr_wr_data) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) :
                       RW'(csr_wr_data - 1'b1);

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      flush_in = flush_ff;
      done_in  = done_ff;
      ph_in    = ph_ff;
      wlast_in = wlast_ff;
      hlast_in = hlast_ff;

      if (smp_acc) begin
         if (col_last) begin
            // row end: stores rotate, lower becomes middle, middle becomes upper
            col_in = '0;
            ph_in  = next_ph;
            if (row_ff == hlast_ff) begin
               done_in  = 1'b1;
               flush_in = '0;
               row_in   = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      if (fl_acc) begin
         if (flush_ff == wlast_ff) begin
            // last flush word: ready for a new frame
            flush_in = '0;
            done_in  = 1'b0;
         end else begin
            flush_in = flush_ff + 1'b1;
         end
      end

      // any size write restarts the frame, stores are kept
      if (csr_wr_en) begin
         col_in   = '0;
         row_in   = '0;
         flush_in = '0;
         done_in  = 1'b0;
         unique case (csr_index)
            gof_pkg::REG_IMAGE_WIDTH:  wlast_in = csr_w_last;
            gof_pkg::REG_IMAGE_HEIGHT: hlast_in = csr_h_last;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= CW'(RST_W - 1);
         hlast_ff <= RW'(RST_H - 1);
         col_ff   <= '0;
         row_ff   <= '0;
         flush_ff <= '0;
         done_ff  <= 1'b0;
         ph_ff    <= '0;
      end else begin
         wlast_ff <= wlast_in;
         hlast_ff <= hlast_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         flush_ff <= flush_in;
         done_ff  <= done_in;
         ph_ff    <= ph_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // row stores
   // reads are issued with the next position so the data for the column an item
   // lands on is already registered when it arrives; port b fetches the right
   // neighbor for flush ticks
   // ---------------------------------------------------------------------------------------
   logic [CW-1:0]               addr_a;
   logic [CW-1:0]               addr_b;
   logic [gof_pkg::ALPHA_W-1:0] rd_a [gof_pkg::ROW_BUFS];
   logic [gof_pkg::ALPHA_W-1:0] rd_b [gof_pkg::ROW_BUFS];
   logic [1:0]                  up_idx;
   logic [1:0]                  mid_idx;

   assign addr_a = done_in ? flush_in : col_in;
   assign addr_b = (addr_a == wlast_ff) ? addr_a : addr_a + 1'b1;

   for (genvar k = 0; k < gof_pkg::ROW_BUFS; k++) begin : g_store
      gof_row_ram #(
         .DEPTH (MAX_WIDTH)
      ) u_store (
         .clock     (clock),
         .wr_en     (smp_acc && (ph_ff == 2'(k))),
         .wr_addr   (col_ff),
         .wr_data   (req_alpha_in),
         .rd_addr_a (addr_a),
         .rd_addr_b (addr_b),
         .rd_data_a (rd_a[k]),
         .rd_data_b (rd_b[k])
      );
   end

   // middle holds the previous row, upper the one before
   always_comb begin
      case (ph_ff)
         2'd0: begin
            up_idx  = 2'd1;
            mid_idx = 2'd2;
         end
         2'd1: begin
            up_idx  = 2'd2;
            mid_idx = 2'd0;
         end
         default: begin
            up_idx  = 2'd0;
            mid_idx = 2'd1;
         end
      endcase
   end

   // top border clamps: the first output row and a single-row frame use the middle row as upper
   logic                 up_is_mid;
   gof_pkg::gof_col_type new_col;
   gof_pkg::gof_col_type new_rt;

   assign up_is_mid = done_ff ? (hlast_ff == '0) : (row_ff == RW'(1));

   always_comb begin
      new_col.up  = up_is_mid ? rd_a[mid_idx] : rd_a[up_idx];
      new_col.mid = rd_a[mid_idx];
      // bottom border clamps on flush: lower row is the middle row
      new_col.dn  = done_ff ? rd_a[mid_idx] : req_alpha_in;
      new_rt.up   = up_is_mid ? rd_b[mid_idx] : rd_b[up_idx];
      new_rt.mid  = rd_b[mid_idx];
      new_rt.dn   = rd_b[mid_idx];
   end

   // ---------------------------------------------------------------------------------------
   // input stage: three-column window plus the emit decision for both lanes
   // lane a: column c-1 of the row above (or the flush column), lane b: last column
   // ---------------------------------------------------------------------------------------
   gof_pkg::gof_col_type win_ff [3];
   gof_pkg::gof_col_type rt_ff;

   logic                      s1_a_ff, s1_a_in;
   logic                      s1_b_ff, s1_b_in;
   logic                      s1_flush_ff;
   logic                      s1_j0_ff;
   logic                      s1_border_ff;
   logic                      s1_c0_ff;
   logic [gof_pkg::POS_W-1:0] s1_row_ff;
   logic [gof_pkg::POS_W-1:0] s1_col_a_ff;
   logic [gof_pkg::POS_W-1:0] s1_col_b_ff;
   logic                      s1_last_ff;

   assign s1_a_in = smp_acc ? ((row_ff != '0) && (col_ff != '0)) : fl_acc;
   assign s1_b_in = smp_acc && (row_ff != '0) && col_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_a_ff <= 1'b0;
         s1_b_ff <= 1'b0;
      end else begin
         s1_a_ff <= s1_a_in;
         s1_b_ff <= s1_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_acc) begin
         win_ff[2]    <= win_ff[1];
         win_ff[1]    <= win_ff[0];
         win_ff[0]    <= new_col;
         rt_ff        <= new_rt;
         s1_flush_ff  <= done_ff;
         s1_j0_ff     <= done_ff ? (flush_ff == '0) : (col_ff == CW'(1));
         s1_border_ff <= done_ff ? ((flush_ff == '0) || (flush_ff == wlast_ff))
                                 : (col_ff == CW'(1));
         s1_c0_ff     <= (col_ff == '0);
         s1_row_ff    <= done_ff ? gof_pkg::POS_W'(hlast_ff)
                                 : gof_pkg::POS_W'(row_ff - 1'b1);
         s1_col_a_ff  <= done_ff ? gof_pkg::POS_W'(flush_ff)
                                 : gof_pkg::POS_W'(col_ff - 1'b1);
         s1_col_b_ff  <= gof_pkg::POS_W'(col_ff);
         s1_last_ff   <= done_ff && (flush_ff == wlast_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // outline lanes, straight into the result queue
   // ---------------------------------------------------------------------------------------
   gof_pkg::gof_col_type la_l, la_c, la_r;
   gof_pkg::gof_col_type lb_l;
   gof_pkg::gof_rsp_type rsp_a;
   gof_pkg::gof_rsp_type rsp_b;

   always_comb begin
      if (s1_flush_ff) begin
         la_l = s1_j0_ff ? win_ff[0] : win_ff[1];
         la_c = win_ff[0];
         la_r = rt_ff;
      end else begin
         // left border clamps to the center column
         la_l = s1_j0_ff ? win_ff[1] : win_ff[2];
         la_c = win_ff[1];
         la_r = win_ff[0];
      end
      // last column: right clamps to center, left clamps too on a one-column frame
      lb_l = s1_c0_ff ? win_ff[0] : win_ff[1];

      rsp_a.alpha = gof_pkg::outline(la_l, la_c, la_r, s1_border_ff);
      rsp_a.row   = s1_row_ff;
      rsp_a.col   = s1_col_a_ff;
      rsp_a.last  = s1_last_ff;

      rsp_b.alpha = gof_pkg::outline(lb_l, win_ff[0], win_ff[0], 1'b1);
      rsp_b.row   = s1_row_ff;
      rsp_b.col   = s1_col_b_ff;
      rsp_b.last  = 1'b0;
   end

   logic [gof_pkg::RSP_CNT_W-1:0] fifo_fill;
   gof_pkg::gof_rsp_type          fifo_head;

   gof_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_a      (s1_a_ff),
      .push_data_a (rsp_a),
      .push_b      (s1_b_ff),
      .push_data_b (rsp_b),
      .pop         (rsp_valid && rsp_ready),
      .out_valid   (rsp_valid),
      .out_data    (fifo_head),
      .fill        (fifo_fill)
   );

   // room for words already in the stage register plus the most a new item can make
   assign req_ready = (gof_pkg::RSP_SUM_W'(fifo_fill) + gof_pkg::RSP_SUM_W'(s1_a_ff) +
                       gof_pkg::RSP_SUM_W'(s1_b_ff) +
                       gof_pkg::RSP_SUM_W'(gof_pkg::MAX_RESULTS)) <=
                      gof_pkg::RSP_SUM_W'(gof_pkg::RSP_DEPTH);

   assign rsp_alpha_out  = fifo_head.alpha;
   assign rsp_out_row    = fifo_head.row;
   assign rsp_out_col    = fifo_head.col;
   assign rsp_frame_last = fifo_head.last;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= wlast_ff) && (flush_ff <= wlast_ff))
      else $error("column counter beyond frame width");

   a_done_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(smp_acc && col_last && (row_ff == hlast_ff)))
      else $error("flush phase entered without the final sample");

   a_lane_b_alone: assert property (@(posedge clock) disable iff (reset)
      (s1_b_ff && !s1_a_ff) |-> s1_c0_ff)
      else $error("last-column word without its neighbor word");

   a_flush_single: assert property (@(posedge clock) disable iff (reset)
      s1_flush_ff && s1_a_ff |-> !s1_b_ff)
      else $error("flush tick produced two words");

endmodule
